### rtl/shct_pkg.sv
// shadow/highlight colour transform: shared types, register indexes and helpers
// no dependencies; imported by shadow_highlight_color_transform_unit
package shct_pkg;

  localparam int unsigned NumChan   = 3;
  localparam int unsigned NumPreset = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 29;

  typedef logic [7:0]  chan_t;
  typedef logic [8:0]  delta_t;
  typedef logic [9:0]  gain_t;
  typedef logic [28:0] preset_t;

  localparam logic [1:0] FMT_INDEXED = 2'd0;
  localparam logic [1:0] FMT_RGB555  = 2'd1;
  localparam logic [1:0] FMT_RGB888  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_PIXEL_FORMAT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_COUNT    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHADOW_GAIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HIGHLIGHT_GAIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PRESET_0       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PRESET_1       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PRESET_2       = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_PRESET_3       = 3'd7;

  localparam int unsigned PresetWrapBit  = 27;
  localparam int unsigned PresetScaleBit = 28;

  localparam delta_t DeltaMinRaw     = 9'h100;
  localparam delta_t DeltaMinClamped = 9'h101;

  localparam preset_t PresetDefaultScale = 29'h1000_0000;

  function automatic chan_t widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

  function automatic delta_t delta9(input delta_t bits);
    delta9 = (bits == DeltaMinRaw) ? DeltaMinClamped : bits;
  endfunction

endpackage

### rtl/shadow_highlight_color_transform_unit.sv
// shadow/highlight colour transform, three-stage pipeline, uses shct_pkg
// an accepted transaction passes through the stage one, stage two and output registers to the output
// throughput: one transaction per cycle; an output stall holds full stages, empty ones fill
// stages: preset decode and widening, gain multiply and delta add, clamp and pack
// reset: pipeline empty, registers at their defaults (rgb888, count 0, gains 153/384)
module shadow_highlight_color_transform_unit
  import shct_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         pixel_i,
  input  logic [1:0]          preset_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [23:0]         pen_out_o
);

  // configuration
  logic [1:0]  fmt_q;
  logic [15:0] count_q;
  gain_t       shadow_gain_q;
  gain_t       highlight_gain_q;
  preset_t     preset_q [NumPreset];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q            <= FMT_RGB888;
      count_q          <= '0;
      shadow_gain_q    <= 10'd153;
      highlight_gain_q <= 10'd384;
      preset_q[0]      <= PresetDefaultScale;
      preset_q[1]      <= PresetDefaultScale;
      preset_q[2]      <= '0;
      preset_q[3]      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIXEL_FORMAT:   fmt_q            <= cfg_data_i[1:0];
        CFG_COLOR_COUNT:    count_q          <= cfg_data_i[15:0];
        CFG_SHADOW_GAIN:    shadow_gain_q    <= cfg_data_i[9:0];
        CFG_HIGHLIGHT_GAIN: highlight_gain_q <= cfg_data_i[9:0];
        CFG_PRESET_0:       preset_q[0]      <= cfg_data_i;
        CFG_PRESET_1:       preset_q[1]      <= cfg_data_i;
        CFG_PRESET_2:       preset_q[2]      <= cfg_data_i;
        CFG_PRESET_3:       preset_q[3]      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flow control
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage 1: preset decode, channel widening, pen compare
  preset_t p_sel;
  chan_t   ch_d [NumChan];
  chan_t   ch1_q [NumChan];
  delta_t  dl1_q [NumChan];
  gain_t   gain1_q;
  logic    scale1_q, wrap1_q, odd1_q, lt1_q;
  logic [15:0] pix1_q;

  assign p_sel   = preset_q[preset_i];
  assign ch_d[0] = widen5(pixel_i[14:10]);
  assign ch_d[1] = widen5(pixel_i[9:5]);
  assign ch_d[2] = widen5(pixel_i[4:0]);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      for (int c = 0; c < NumChan; c++) begin
        ch1_q[c] <= ch_d[c];
        dl1_q[c] <= delta9(p_sel[9*c +: 9]);
      end
      gain1_q  <= preset_i[0] ? highlight_gain_q : shadow_gain_q;
      scale1_q <= p_sel[PresetScaleBit];
      wrap1_q  <= p_sel[PresetWrapBit];
      odd1_q   <= preset_i[0];
      lt1_q    <= pixel_i < count_q;
      pix1_q   <= pixel_i;
    end
  end

  // stage 2: gain multiply, delta add, pen offset
  logic [17:0] prod2_q [NumChan];
  logic [9:0]  sum2_q  [NumChan];
  logic        scale2_q, wrap2_q, lt2_q;
  logic [17:0] isum2_q;
  logic [15:0] pix2_q;
  logic [16:0] addend;

  assign addend = odd1_q ? {count_q, 1'b0} : {1'b0, count_q};

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      for (int c = 0; c < NumChan; c++) begin
        prod2_q[c] <= {10'd0, ch1_q[c]} * {8'd0, gain1_q};
        sum2_q[c]  <= {2'b00, ch1_q[c]} + {dl1_q[c][8], dl1_q[c]};
      end
      scale2_q <= scale1_q;
      wrap2_q  <= wrap1_q;
      lt2_q    <= lt1_q;
      isum2_q  <= {2'b00, pix1_q} + {1'b0, addend};
      pix2_q   <= pix1_q;
    end
  end

  // stage 3: clamp or wrap, then pack
  chan_t       res [NumChan];
  logic [23:0] pen_d;
  logic [23:0] pen3_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if (scale2_q) begin
        res[c] = (|prod2_q[c][17:16]) ? 8'hff : prod2_q[c][15:8];
      end else if (wrap2_q) begin
        res[c] = sum2_q[c][7:0];
      end else if (sum2_q[c][9]) begin
        res[c] = 8'h00;
      end else if (sum2_q[c][8]) begin
        res[c] = 8'hff;
      end else begin
        res[c] = sum2_q[c][7:0];
      end
    end
    case (fmt_q)
      FMT_INDEXED: begin
        if (!lt2_q) begin
          pen_d = {8'd0, pix2_q};
        end else if (|isum2_q[17:16]) begin
          pen_d = 24'h00ffff;
        end else begin
          pen_d = {8'd0, isum2_q[15:0]};
        end
      end
      FMT_RGB555: pen_d = {9'd0, res[0][7:3], res[1][7:3], res[2][7:3]};
      default:    pen_d = {res[0], res[1], res[2]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv3) pen3_q <= pen_d;
  end

  assign out_valid_o = v3_q;
  assign pen_out_o   = pen3_q;

  // checks
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled while the pipeline has a free stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted transaction missing from stage one");

  a_hold_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !adv3) |=> v2_q)
    else $error("stage two transaction dropped during a stall");

  a_indexed_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fmt_q == FMT_INDEXED) |-> (pen_out_o[23:16] == 8'd0))
    else $error("indexed pen wider than 16 bits");

  a_rgb555_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fmt_q == FMT_RGB555) |-> (pen_out_o[23:15] == 9'd0))
    else $error("rgb555 pen wider than 15 bits");

endmodule

### sim/shct_pen_check_pkg.sv
// shadow/highlight colour transform testbench: pen predictor and scoreboard class
// depends on shct_pkg for register indexes, formats and field types
package shct_pen_check_pkg;
  import shct_pkg::*;

  typedef struct packed {
    logic [15:0] pixel;
    logic [1:0]  preset;
    logic [23:0] pen;
  } pen_expect_t;

  class pen_scoreboard;
    logic [1:0]  fmt;
    logic [15:0] count;
    gain_t       shadow_gain;
    gain_t       highlight_gain;
    preset_t     presets[NumPreset];
    pen_expect_t awaiting[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      fmt            = FMT_RGB888;
      count          = '0;
      shadow_gain    = 10'd153;
      highlight_gain = 10'd384;
      presets[0]     = PresetDefaultScale;
      presets[1]     = PresetDefaultScale;
      presets[2]     = '0;
      presets[3]     = '0;
      mismatches     = 0;
      checked        = 0;
    endfunction

    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_PIXEL_FORMAT:   fmt = data[1:0];
        CFG_COLOR_COUNT:    count = data[15:0];
        CFG_SHADOW_GAIN:    shadow_gain = data[9:0];
        CFG_HIGHLIGHT_GAIN: highlight_gain = data[9:0];
        CFG_PRESET_0:       presets[0] = data;
        CFG_PRESET_1:       presets[1] = data;
        CFG_PRESET_2:       presets[2] = data;
        CFG_PRESET_3:       presets[3] = data;
        default: ;
      endcase
    endfunction

    function int scaled(int c, gain_t gain);
      int v;
      v = (c * int'(gain)) >>> 8;
      return (v > 255) ? 255 : v;
    endfunction

    function int shifted(int c, delta_t raw, bit wrap);
      int d;
      int v;
      // most negative delta saturates one step in
      d = (raw == DeltaMinRaw) ? -255 : int'($signed(raw));
      v = c + d;
      if (wrap) return v & 255;
      if (v < 0) return 0;
      return (v > 255) ? 255 : v;
    endfunction

    function logic [23:0] predict_pen(logic [15:0] pix, logic [1:0] sel);
      int      chan[3];
      int      sum;
      preset_t p;
      bit      odd;
      odd = sel[0];
      if (fmt == FMT_INDEXED) begin
        if (pix >= count) return {8'h00, pix};
        sum = int'(pix) + (odd ? 2 * int'(count) : int'(count));
        return (sum > 65535) ? 24'h00ffff : 24'(sum);
      end
      chan[0] = int'({pix[14:10], pix[14:12]});
      chan[1] = int'({pix[9:5], pix[9:7]});
      chan[2] = int'({pix[4:0], pix[4:2]});
      p = presets[sel];
      for (int i = 0; i < NumChan; i++) begin
        if (p[PresetScaleBit]) begin
          chan[i] = scaled(chan[i], odd ? highlight_gain : shadow_gain);
        end else begin
          chan[i] = shifted(chan[i], p[9*i +: 9], p[PresetWrapBit]);
        end
      end
      if (fmt == FMT_RGB555) begin
        return {9'd0, 5'(chan[0] >> 3), 5'(chan[1] >> 3), 5'(chan[2] >> 3)};
      end
      return {8'(chan[0]), 8'(chan[1]), 8'(chan[2])};
    endfunction

    function void note_pixel(logic [15:0] pix, logic [1:0] sel);
      pen_expect_t e;
      e.pixel  = pix;
      e.preset = sel;
      e.pen    = predict_pen(pix, sel);
      awaiting.push_back(e);
    endfunction

    function int unsigned pending();
      return awaiting.size();
    endfunction

    task report(string what, logic [15:0] pix, logic [1:0] sel,
                logic [23:0] got, logic [23:0] want);
      mismatches++;
      if (mismatches <= 100) begin
        $display("mismatch %s: pixel %h preset %0d got %h want %h",
                 what, pix, sel, got, want);
      end
    endtask

    task check_pen(logic [23:0] got);
      pen_expect_t e;
      checked++;
      if (awaiting.size() == 0) begin
        report("unexpected transaction", '0, '0, got, '0);
        return;
      end
      e = awaiting.pop_front();
      if (got !== e.pen) report("pen_out", e.pixel, e.preset, got, e.pen);
    endtask
  endclass

endpackage

### sim/tb_top.sv
// shadow/highlight colour transform testbench top: clock, reset, drivers and monitor
// drives shadow_highlight_color_transform_unit with directed then random pixels
// depends on shct_pkg and shct_pen_check_pkg
module tb_top;
  import shct_pkg::*;
  import shct_pen_check_pkg::*;

  localparam logic [1:0]  FMT_RGB888_ALIAS = 2'd3;
  localparam int unsigned CycleLimit       = 600000;
  localparam int unsigned TargetItems      = 1650;
  localparam int unsigned DrainCycles      = 8;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic [15:0]         pixel_i    = '0;
  logic [1:0]          preset_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [23:0]         pen_out_o;

  bit            quiet_tx;
  bit            quiet_rx;
  int unsigned   cycles;
  int unsigned   sent;
  int unsigned   settings;
  pen_scoreboard sb = new();

  shadow_highlight_color_transform_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .preset_i    (preset_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pen_out_o   (pen_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_pixel(pixel_i, preset_i);
      if (out_valid_o && !out_stall_i) sb.check_pen(pen_out_o);
    end
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // output side back-pressure
  initial begin
    int unsigned n;
    @(posedge clk_i);
    forever begin
      n = pick_gap(quiet_rx);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  function automatic preset_t pack_preset(bit scale, bit wrap, delta_t r, delta_t g, delta_t b);
    return {scale, wrap, b, g, r};
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 10'd1023;
      2:       return 10'd256;
      default: return gain_t'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic preset_t pick_preset();
    preset_t p;
    p = preset_t'($urandom());
    if ($urandom_range(0, 5) == 0) p[8:0] = DeltaMinRaw;
    if ($urandom_range(0, 5) == 0) p[26:18] = DeltaMinRaw;
    return p;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.apply_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [1:0] fmt, input logic [15:0] count,
                              input gain_t sg, input gain_t hg, input preset_t p0,
                              input preset_t p1, input preset_t p2, input preset_t p3);
    write_reg(CFG_PIXEL_FORMAT, CfgDataW'(fmt));
    write_reg(CFG_COLOR_COUNT, CfgDataW'(count));
    write_reg(CFG_SHADOW_GAIN, CfgDataW'(sg));
    write_reg(CFG_HIGHLIGHT_GAIN, CfgDataW'(hg));
    write_reg(CFG_PRESET_0, p0);
    write_reg(CFG_PRESET_1, p1);
    write_reg(CFG_PRESET_2, p2);
    write_reg(CFG_PRESET_3, p3);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic send_pixel(input logic [15:0] pix, input logic [1:0] sel);
    int unsigned gap;
    gap = pick_gap(quiet_tx);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    preset_i   <= sel;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // hold off the sender until every pen is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [1:0]  fmt;
    logic [15:0] count;
    logic [15:0] pix;
    int unsigned phase;
    int unsigned n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset, pixel top bit set on some
    send_pixel(16'h7fff, 2'd0);
    send_pixel(16'h7fff, 2'd1);
    send_pixel(16'hffff, 2'd2);
    send_pixel(16'h8000, 2'd3);
    drain();

    // indexed: bank offsets, exact top, saturation, pass-through at the count
    load_setting(FMT_INDEXED, 16'h8000, 10'd153, 10'd384, '0, '0, '0, '0);
    send_pixel(16'h0000, 2'd0);
    send_pixel(16'h7fff, 2'd1);
    send_pixel(16'h7fff, 2'd2);
    send_pixel(16'h8000, 2'd3);
    send_pixel(16'hffff, 2'd1);
    drain();
    load_setting(FMT_INDEXED, 16'hffff, 10'd1023, 10'd0, '1, '1, '1, '1);
    send_pixel(16'hfffe, 2'd0);
    send_pixel(16'hffff, 2'd1);
    drain();

    // rgb555: gain extremes, wrap ignored when scaling, most negative delta
    load_setting(FMT_RGB555, 16'h0000, 10'd0, 10'd1023,
                 pack_preset(1'b1, 1'b1, 9'h000, 9'h000, 9'h000),
                 pack_preset(1'b1, 1'b0, 9'h000, 9'h000, 9'h000),
                 pack_preset(1'b0, 1'b1, DeltaMinRaw, DeltaMinRaw, DeltaMinRaw),
                 pack_preset(1'b0, 1'b0, DeltaMinRaw, 9'h0ff, 9'h1ff));
    send_pixel(16'h7fff, 2'd0);
    send_pixel(16'h7fff, 2'd1);
    send_pixel(16'h0421, 2'd1);
    send_pixel(16'h7fff, 2'd2);
    send_pixel(16'h0000, 2'd2);
    send_pixel(16'h7fff, 2'd3);
    send_pixel(16'h0000, 2'd3);
    drain();

    // format code three acts as rgb888, largest positive delta clamped and wrapped
    load_setting(FMT_RGB888_ALIAS, 16'h1234, 10'd512, 10'd700,
                 pack_preset(1'b0, 1'b0, 9'h0ff, 9'h0ff, 9'h0ff),
                 pack_preset(1'b0, 1'b1, 9'h0ff, 9'h0ff, 9'h0ff),
                 PresetDefaultScale, PresetDefaultScale);
    send_pixel(16'h5294, 2'd0);
    send_pixel(16'h5294, 2'd1);
    send_pixel(16'haaaa, 2'd2);
    send_pixel(16'h5555, 2'd3);
    drain();

    phase = 0;
    while (sent < TargetItems) begin
      quiet_tx = ($urandom_range(0, 3) == 0);
      quiet_rx = ($urandom_range(0, 3) == 0);
      fmt = 2'(phase % 4);
      case ($urandom_range(0, 5))
        0:       count = 16'h0000;
        1:       count = 16'hffff;
        2:       count = 16'h8000;
        default: count = 16'($urandom_range(0, 65535));
      endcase
      load_setting(fmt, count, pick_gain(), pick_gain(), pick_preset(), pick_preset(),
                   pick_preset(), pick_preset());
      n = $urandom_range(100, 180);
      repeat (n) begin
        if (fmt == FMT_INDEXED && $urandom_range(0, 1) == 0) begin
          pix = 16'(int'(count) + int'($urandom_range(0, 8)) - 4);
        end else begin
          pix = 16'($urandom_range(0, 65535));
        end
        send_pixel(pix, 2'($urandom_range(0, 3)));
      end
      drain();
      phase++;
    end

    $display("covered %0d pixels under %0d register settings, all four formats and presets",
             sent, settings);
    $display("%0d pens checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
